/* rtl/idd_pkg.sv */
// ----------------------------------------------------------------------------
// Image descriptor decoder package
// Shared types, constants and the unified format table for the decoder.
// ----------------------------------------------------------------------------
package idd_pkg;

  // Tiling index codes.
  localparam logic [6:0] TILE_LINEAR   = 7'h08;
  localparam logic [6:0] TILE_STD_0    = 7'h50;
  localparam logic [6:0] TILE_STD_1    = 7'h51;
  localparam logic [6:0] TILE_STD_2    = 7'h52;
  localparam logic [6:0] TILE_SWZ_BASE = 7'h40;

  // Swizzle mode codes with a dedicated tiling index.
  localparam logic [4:0] SWZ_LINEAR = 5'd0;
  localparam logic [4:0] SWZ_STD_0  = 5'd1;
  localparam logic [4:0] SWZ_STD_1  = 5'd5;
  localparam logic [4:0] SWZ_STD_2  = 5'd9;

  // Image type codes.
  localparam logic [3:0] KIND_VOL_0 = 4'd10;
  localparam logic [3:0] KIND_VOL_1 = 4'd11;
  localparam logic [3:0] KIND_ARR_0 = 4'd12;
  localparam logic [3:0] KIND_ARR_1 = 4'd13;

  // Data format codes and limits.
  localparam logic [5:0]  DFMT_NONE        = 6'd0;
  localparam logic [5:0]  DFMT_64BIT       = 6'd12;
  localparam logic [5:0]  DFMT_BLOCK_FIRST = 6'd35;
  localparam logic [16:0] MAX_LAYERS       = 17'd16384;
  localparam logic [14:0] MAX_EXTENT       = 15'd16384;

  // Stage 1 to stage 2 payload.
  typedef struct packed {
    logic [39:0] units;
    logic [11:0] lod_min;
    logic [14:0] wd;
    logic [14:0] ht;
    logic [3:0]  first_mip;
    logic [3:0]  top_level;
    logic [3:0]  top_mip;
    logic [6:0]  tiling;
    logic [3:0]  kind;
    logic        is_array;
    logic        is_volume;
    logic [11:0] sels;
    logic [15:0] depth_m1;
    logic [15:0] first_layer;
    logic [5:0]  data_fmt;
    logic [3:0]  num_fmt;
  } dec_t;

  // Stage 2 to stage 3 payload.
  typedef struct packed {
    logic [39:0] units;
    logic [11:0] lod_min;
    logic [14:0] wd;
    logic [14:0] ht;
    logic [14:0] pitch;
    logic [16:0] layer_count;
    logic [16:0] layer_span;
    logic [15:0] first_layer;
    logic        array_ok;
    logic [3:0]  first_mip;
    logic [3:0]  top_level;
    logic [4:0]  level_count;
    logic [4:0]  view_levels;
    logic [3:0]  level_cap;
    logic [6:0]  tiling;
    logic [3:0]  kind;
    logic        is_array;
    logic [11:0] sels;
    logic [5:0]  data_fmt;
    logic [3:0]  num_fmt;
  } calc_t;

  // Result payload.
  typedef struct packed {
    logic [47:0] base_address;
    logic [14:0] width;
    logic [14:0] height;
    logic [14:0] pitch;
    logic [49:0] layer_fields;
    logic [25:0] mip_fields;
    logic [9:0]  format_pair;
    logic [6:0]  tiling_index;
    logic [11:0] channel_selects;
    logic [5:0]  type_flags;
    logic        valid_res;
  } res_t;

  // Unified format code to {data format, number format}; unknown codes give zero.
  function automatic logic [9:0] fmt_lookup(input logic [8:0] code);
    logic [9:0] r;
    begin
      unique case (code)
        9'd1:   r = {6'd1, 4'd0};
        9'd2:   r = {6'd1, 4'd1};
        9'd5:   r = {6'd1, 4'd4};
        9'd6:   r = {6'd1, 4'd5};
        9'd7:   r = {6'd2, 4'd0};
        9'd11:  r = {6'd2, 4'd4};
        9'd13:  r = {6'd2, 4'd7};
        9'd14:  r = {6'd3, 4'd0};
        9'd18:  r = {6'd3, 4'd4};
        9'd20:  r = {6'd4, 4'd4};
        9'd21:  r = {6'd4, 4'd5};
        9'd22:  r = {6'd4, 4'd7};
        9'd23:  r = {6'd5, 4'd0};
        9'd27:  r = {6'd5, 4'd4};
        9'd29:  r = {6'd5, 4'd7};
        9'd36:  r = {6'd6, 4'd7};
        9'd44:  r = {6'd9, 4'd0};
        9'd50:  r = {6'd8, 4'd0};
        9'd56:  r = {6'd10, 4'd0};
        9'd57:  r = {6'd10, 4'd1};
        9'd60:  r = {6'd10, 4'd4};
        9'd62:  r = {6'd11, 4'd4};
        9'd64:  r = {6'd11, 4'd7};
        9'd71:  r = {6'd12, 4'd7};
        9'd74:  r = {6'd13, 4'd7};
        9'd77:  r = {6'd14, 4'd7};
        9'd130: r = {6'd10, 4'd9};
        9'd169: r = {6'd35, 4'd0};
        9'd170: r = {6'd35, 4'd9};
        9'd171: r = {6'd36, 4'd0};
        9'd172: r = {6'd36, 4'd9};
        9'd173: r = {6'd37, 4'd0};
        9'd174: r = {6'd37, 4'd9};
        9'd175: r = {6'd38, 4'd0};
        9'd176: r = {6'd38, 4'd1};
        9'd177: r = {6'd39, 4'd0};
        9'd178: r = {6'd39, 4'd1};
        9'd181: r = {6'd41, 4'd0};
        9'd182: r = {6'd41, 4'd9};
        default: r = 10'd0;
      endcase
      return r;
    end
  endfunction

endpackage

/* rtl/idd_if.sv */
// ----------------------------------------------------------------------------
// Image descriptor decoder channels
// Valid/ready channels for descriptor requests and decoded results.
// ----------------------------------------------------------------------------
interface idd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] word0;
  logic [31:0] word1;
  logic [31:0] word2;
  logic [31:0] word3;
  logic [31:0] word4;
  logic [31:0] word5;

  modport source (output valid, word0, word1, word2, word3, word4, word5, input ready);
  modport sink   (input valid, word0, word1, word2, word3, word4, word5, output ready);
endinterface

interface idd_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] base_address;
  logic [14:0] width;
  logic [14:0] height;
  logic [14:0] pitch;
  logic [49:0] layer_fields;
  logic [25:0] mip_fields;
  logic [9:0]  format_pair;
  logic [6:0]  tiling_index;
  logic [11:0] channel_selects;
  logic [5:0]  type_flags;
  logic        valid_res;

  modport source (output valid, base_address, width, height, pitch, layer_fields,
                  mip_fields, format_pair, tiling_index, channel_selects,
                  type_flags, valid_res, input ready);
  modport sink   (input valid, base_address, width, height, pitch, layer_fields,
                  mip_fields, format_pair, tiling_index, channel_selects,
                  type_flags, valid_res, output ready);
endinterface

/* rtl/idd_decode.sv */
// ----------------------------------------------------------------------------
// Image descriptor decoder, stage 1
// Field extraction, format table lookup and tiling index encode.
// ----------------------------------------------------------------------------
module idd_decode import idd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] w0,
  input  logic [31:0] w1,
  input  logic [31:0] w2,
  input  logic [31:0] w3,
  input  logic [31:0] w4,
  input  logic [31:0] w5,
  output logic        out_valid,
  input  logic        out_ready,
  output dec_t        out_data
);

  logic valid_r;
  dec_t data_r;
  dec_t data_nxt;
  logic [9:0] fmt;
  logic [4:0] swz;

  // The stage takes a request when it is empty or its content moves on.
  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  assign fmt = fmt_lookup(w1[28:20]);
  assign swz = w3[24:20];

  // Field extraction.
  always_comb begin
    data_nxt.units       = {w1[7:0], w0};
    data_nxt.lod_min     = w1[19:8];
    data_nxt.wd          = {1'b0, w2[11:0], w1[31:30]} + 15'd1;
    data_nxt.ht          = {1'b0, w2[27:14]} + 15'd1;
    data_nxt.first_mip   = w3[15:12];
    data_nxt.top_level   = w3[19:16];
    data_nxt.top_mip     = w5[7:4];
    data_nxt.kind        = w3[31:28];
    data_nxt.is_array    = (w3[31:28] == KIND_ARR_0) || (w3[31:28] == KIND_ARR_1);
    data_nxt.is_volume   = (w3[31:28] == KIND_VOL_0) || (w3[31:28] == KIND_VOL_1);
    data_nxt.sels        = w3[11:0];
    data_nxt.depth_m1    = w4[15:0];
    data_nxt.first_layer = w4[31:16];
    data_nxt.data_fmt    = fmt[9:4];
    data_nxt.num_fmt     = fmt[3:0];
    priority if (swz == SWZ_LINEAR) begin
      data_nxt.tiling = TILE_LINEAR;
    end else if (swz == SWZ_STD_0) begin
      data_nxt.tiling = TILE_STD_0;
    end else if (swz == SWZ_STD_1) begin
      data_nxt.tiling = TILE_STD_1;
    end else if (swz == SWZ_STD_2) begin
      data_nxt.tiling = TILE_STD_2;
    end else begin
      data_nxt.tiling = TILE_SWZ_BASE + {2'b00, swz};
    end
  end

  // Stage valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* rtl/idd_calc.sv */
// ----------------------------------------------------------------------------
// Image descriptor decoder, stage 2
// Layer and mip counts, pitch alignment and the mip level limit.
// ----------------------------------------------------------------------------
module idd_calc import idd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  dec_t  in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output calc_t out_data
);

  logic  valid_r;
  calc_t data_r;
  calc_t data_nxt;
  logic [16:0] depth;
  logic        layer_in_range;
  logic [14:0] ext;
  logic [3:0]  cap;
  logic        align_pitch;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  assign depth          = {1'b0, in_data.depth_m1} + 17'd1;
  assign layer_in_range = in_data.first_layer <= in_data.depth_m1;
  assign ext            = (in_data.wd > in_data.ht) ? in_data.wd : in_data.ht;
  assign align_pitch    = (in_data.tiling == TILE_LINEAR) &&
                          (in_data.data_fmt != DFMT_NONE) &&
                          (in_data.data_fmt < DFMT_BLOCK_FIRST);

  // Level limit is the bit length of the larger extent.
  always_comb begin
    cap = 4'd1;
    for (int i = 1; i < 15; i++) begin
      if (ext[i]) begin
        cap = 4'(i + 1);
      end
    end
  end

  // Counts and pitch.
  always_comb begin
    data_nxt.units       = in_data.units;
    data_nxt.lod_min     = in_data.lod_min;
    data_nxt.wd          = in_data.wd;
    data_nxt.ht          = in_data.ht;
    data_nxt.first_layer = in_data.first_layer;
    data_nxt.first_mip   = in_data.first_mip;
    data_nxt.top_level   = in_data.top_level;
    data_nxt.tiling      = in_data.tiling;
    data_nxt.kind        = in_data.kind;
    data_nxt.is_array    = in_data.is_array;
    data_nxt.sels        = in_data.sels;
    data_nxt.data_fmt    = in_data.data_fmt;
    data_nxt.num_fmt     = in_data.num_fmt;
    data_nxt.level_cap   = cap;
    data_nxt.level_count = {1'b0, in_data.top_mip} + 5'd1;
    data_nxt.layer_count = (in_data.is_array || in_data.is_volume) ? depth : 17'd1;
    data_nxt.array_ok    = !in_data.is_array || layer_in_range;
    if (in_data.is_array && layer_in_range) begin
      data_nxt.layer_span = depth - {1'b0, in_data.first_layer};
    end else begin
      data_nxt.layer_span = 17'd1;
    end
    if (in_data.first_mip <= in_data.top_level) begin
      data_nxt.view_levels = {1'b0, in_data.top_level} + 5'd1 - {1'b0, in_data.first_mip};
    end else begin
      data_nxt.view_levels = 5'd1;
    end
    // Linear rows of non-block formats align to 32 texels (256 bytes) for 64-bit formats, else to 64 texels.
    if (!align_pitch) begin
      data_nxt.pitch = in_data.wd;
    end else if (in_data.data_fmt == DFMT_64BIT) begin
      data_nxt.pitch = (in_data.wd + 15'd31) & ~15'd31;
    end else begin
      data_nxt.pitch = (in_data.wd + 15'd63) & ~15'd63;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* rtl/idd_check.sv */
// ----------------------------------------------------------------------------
// Image descriptor decoder, stage 3
// Mip check, single-level forcing for standard tiling, validity and packing.
// ----------------------------------------------------------------------------
module idd_check import idd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  calc_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  out_data
);

  logic valid_r;
  res_t data_r;
  res_t data_nxt;
  logic mips_ok;
  logic force_one;
  logic ok;
  logic [11:0] lod_min;
  logic [3:0]  first_mip;
  logic [4:0]  levels;
  logic [4:0]  view_levels;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  // Mip range check uses the counts before standard-tiling forcing.
  assign mips_ok = (in_data.first_mip <= in_data.top_level) &&
                   (in_data.top_level < in_data.level_cap) &&
                   (({2'b00, in_data.first_mip} + {1'b0, in_data.view_levels}) <=
                    {1'b0, in_data.level_count});

  assign force_one = ((in_data.tiling == TILE_STD_0) || (in_data.tiling == TILE_STD_1) ||
                      (in_data.tiling == TILE_STD_2)) && (in_data.level_count > 5'd1);

  assign lod_min     = force_one ? 12'd0 : in_data.lod_min;
  assign first_mip   = force_one ? 4'd0 : in_data.first_mip;
  assign levels      = force_one ? 5'd1 : in_data.level_count;
  assign view_levels = force_one ? 5'd1 : in_data.view_levels;

  // The byte address is at least 64 KiB when any unit bit above bit 7 is set.
  assign ok = (in_data.units[39:8] != 32'd0) && (in_data.data_fmt != DFMT_NONE) &&
              (in_data.wd <= MAX_EXTENT) && (in_data.ht <= MAX_EXTENT) &&
              (in_data.layer_count <= MAX_LAYERS) && in_data.array_ok && mips_ok;

  // Result packing.
  always_comb begin
    data_nxt.base_address    = {in_data.units, 8'h00};
    data_nxt.width           = in_data.wd;
    data_nxt.height          = in_data.ht;
    data_nxt.pitch           = in_data.pitch;
    data_nxt.layer_fields    = {in_data.layer_count, in_data.layer_span,
                                in_data.first_layer};
    data_nxt.mip_fields      = {lod_min, first_mip, view_levels, levels};
    data_nxt.format_pair     = {in_data.data_fmt, in_data.num_fmt};
    data_nxt.tiling_index    = in_data.tiling;
    data_nxt.channel_selects = in_data.sels;
    data_nxt.type_flags      = {in_data.kind, in_data.is_array, force_one};
    data_nxt.valid_res       = ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* rtl/image_descriptor_decoder.sv */
// ----------------------------------------------------------------------------
// Image descriptor decoder
// Decodes six-word image descriptors into addresses, extents, counts,
// format, tiling index and a validity flag.
//
// Usage: a request on in_if carries descriptor words 0 to 5; each request
// gives exactly one result on out_if, in request order. Both channels use
// valid/ready and move data at a clock edge where both are high.
// Path: an accepted request passes the decode, count and check stages, each
// ending in a register, before its result appears on out_if.
// Throughput: one request per cycle, sustained as long as out_if is ready.
// Stall: each stage holds its content while the next one is full and
// blocked; in_if.ready falls once all three stages are full and out_if is
// not ready, so no request is lost or repeated. A result stays on out_if
// until it is taken. Reset: synchronous, active low; all stages are emptied
// and out_if.valid is low. There is no other state.
// ----------------------------------------------------------------------------
module image_descriptor_decoder import idd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  idd_in_if.sink     in_if,
  idd_out_if.source  out_if
);

  logic  dec_valid;
  logic  dec_ready;
  dec_t  dec_data;
  logic  calc_valid;
  logic  calc_ready;
  calc_t calc_data;
  res_t  res;

  // Stage 1: field extraction and format lookup.
  idd_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .w0        (in_if.word0),
    .w1        (in_if.word1),
    .w2        (in_if.word2),
    .w3        (in_if.word3),
    .w4        (in_if.word4),
    .w5        (in_if.word5),
    .out_valid (dec_valid),
    .out_ready (dec_ready),
    .out_data  (dec_data)
  );

  // Stage 2: counts, pitch and level limit.
  idd_calc u_calc (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dec_valid),
    .in_ready  (dec_ready),
    .in_data   (dec_data),
    .out_valid (calc_valid),
    .out_ready (calc_ready),
    .out_data  (calc_data)
  );

  // Stage 3: checks and result register.
  idd_check u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (calc_valid),
    .in_ready  (calc_ready),
    .in_data   (calc_data),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_data  (res)
  );

  // Result fields onto the output channel.
  assign out_if.base_address    = res.base_address;
  assign out_if.width           = res.width;
  assign out_if.height          = res.height;
  assign out_if.pitch           = res.pitch;
  assign out_if.layer_fields    = res.layer_fields;
  assign out_if.mip_fields      = res.mip_fields;
  assign out_if.format_pair     = res.format_pair;
  assign out_if.tiling_index    = res.tiling_index;
  assign out_if.channel_selects = res.channel_selects;
  assign out_if.type_flags      = res.type_flags;
  assign out_if.valid_res       = res.valid_res;

endmodule
